// ----- rtl/dcsag_pkg.sv -----
package dcsag_pkg;

	// frame and size limits
	localparam int SAMPLES_PER_FRAME = 32;
	localparam int MAX_CHANNELS      = 4096;
	localparam int LANE_W            = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;

	// field widths
	localparam int WORD_W = 32;
	localparam int DIM_W  = 16;
	localparam int CH_W   = 13;
	localparam int DST_W  = 17;
	localparam int BF_W   = 16;
	localparam int IDX_W  = 3;

	// stream widths (fields packed from bit 0, padded to whole bytes)
	localparam int S_FIELDS_W = 4 * WORD_W + 2 * BF_W + 2 + WORD_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 3 * WORD_W + DST_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// bfloat16 floor constants
	localparam logic [7:0] MANT_HIDDEN = 8'h80;
	localparam logic [6:0] MANT_MASK   = 7'h7f;
	localparam int         EXP_BIAS    = 127;
	localparam int         OFFSET_BIAS = 63;
	localparam int         SHIFT_LIMIT = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_IMG_HEIGHT = 3'd0,
		REG_IMG_WIDTH  = 3'd1,
		REG_CHANNELS   = 3'd2,
		REG_Q_RESTART  = 3'd3,
		REG_P_STEP     = 3'd4,
		REG_Q_STEP     = 3'd5,
		REG_Q_END      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0]  img_height;
		logic [DIM_W-1:0]  img_width;
		logic [CH_W-1:0]   channels;
		logic [WORD_W-1:0] q_restart;
		logic [WORD_W-1:0] p_step;
		logic [WORD_W-1:0] q_step;
		logic [WORD_W-1:0] q_end;
	} cfg_t;

	// one sample after the front part: absolute position plus bookkeeping
	typedef struct packed {
		logic [WORD_W-1:0] h;
		logic [WORD_W-1:0] w;
		logic [WORD_W-1:0] image_base;
		logic [DST_W-1:0]  dst_index;
		logic [WORD_W-1:0] p_next;
		logic [WORD_W-1:0] q_next;
		logic              last;
	} item_t;

	// floor of a non-negative bfloat16 value, 0 for small exponents, wide shifts and negative values
	function automatic logic [WORD_W-1:0] bf16_floor(input logic [BF_W-1:0] b);
		logic [8:0]        e;
		logic [8:0]        sh;
		logic [WORD_W-1:0] m;
		logic [WORD_W-1:0] r;
		e  = b[15:7];
		sh = e - 9'(EXP_BIAS);
		m  = {24'b0, MANT_HIDDEN | {1'b0, b[6:0] & MANT_MASK}};
		if ((e < 9'(EXP_BIAS)) || (sh >= 9'(SHIFT_LIMIT))) begin
			r = '0;
		end else begin
			r = (m << sh[4:0]) >> 7;
		end
		return r;
	endfunction

endpackage

// ----- rtl/dcsag_cfg.sv -----
module dcsag_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dcsag_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dcsag_pkg::WORD_W-1:0] cfg_data,
	output dcsag_pkg::cfg_t              cfg
);

	dcsag_pkg::cfg_t               cfg_q;
	logic [dcsag_pkg::CH_W-1:0]    ch_raw;
	logic [dcsag_pkg::CH_W-1:0]    ch_sat;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// channel count (low 13 bits of the data word) saturates at the largest supported value
	assign ch_raw = cfg_data[dcsag_pkg::CH_W-1:0];
	assign ch_sat = ({19'b0, ch_raw} > 32'(dcsag_pkg::MAX_CHANNELS))
		? dcsag_pkg::CH_W'(dcsag_pkg::MAX_CHANNELS) : ch_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.img_height <= 16'd1;
			cfg_q.img_width  <= 16'd1;
			cfg_q.channels   <= 13'd32;
			cfg_q.q_restart  <= '0;
			cfg_q.p_step     <= '0;
			cfg_q.q_step     <= 32'd1;
			cfg_q.q_end      <= 32'd32;
		end else if (cfg_valid && cfg_ready) begin
			case (dcsag_pkg::cfg_reg_t'(cfg_index))
				dcsag_pkg::REG_IMG_HEIGHT: cfg_q.img_height <= cfg_data[15:0];
				dcsag_pkg::REG_IMG_WIDTH:  cfg_q.img_width  <= cfg_data[15:0];
				dcsag_pkg::REG_CHANNELS:   cfg_q.channels   <= ch_sat;
				dcsag_pkg::REG_Q_RESTART:  cfg_q.q_restart  <= cfg_data;
				dcsag_pkg::REG_P_STEP:     cfg_q.p_step     <= cfg_data;
				dcsag_pkg::REG_Q_STEP:     cfg_q.q_step     <= cfg_data;
				dcsag_pkg::REG_Q_END:      cfg_q.q_end      <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/dcsag_front.sv -----
module dcsag_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dcsag_pkg::cfg_t                 cfg,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dcsag_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                            s_tuser,
	input  logic                            full,
	output logic                            push,
	output dcsag_pkg::item_t                push_item
);

	logic [dcsag_pkg::WORD_W-1:0] row_q, col_q;
	logic [dcsag_pkg::LANE_W-1:0] lane_q;
	logic [dcsag_pkg::DST_W-1:0]  dst_q;

	logic [dcsag_pkg::WORD_W-1:0] p_init, q_init, tap_row, tap_col, image_base;
	logic [dcsag_pkg::BF_W-1:0]   offset_h_bf16, offset_w_bf16;
	logic                         corner_h, corner_w;

	logic [dcsag_pkg::WORD_W-1:0] row_eff, col_eff, oh, ow, col_stp, row_nxt, col_nxt;
	logic [dcsag_pkg::LANE_W-1:0] lane_eff, lane_nxt;
	logic [dcsag_pkg::DST_W-1:0]  dst_eff, dst_nxt;
	logic                         wrap, last;

	assign p_init        = s_tdata[31:0];
	assign q_init        = s_tdata[63:32];
	assign offset_h_bf16 = s_tdata[79:64];
	assign offset_w_bf16 = s_tdata[95:80];
	assign tap_row       = s_tdata[127:96];
	assign tap_col       = s_tdata[159:128];
	assign corner_h      = s_tdata[160];
	assign corner_w      = s_tdata[161];
	assign image_base    = s_tdata[193:162];

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	always_comb begin
		row_eff  = s_tuser ? p_init : row_q;
		col_eff  = s_tuser ? q_init : col_q;
		lane_eff = s_tuser ? '0 : lane_q;
		dst_eff  = s_tuser ? '0 : dst_q;

		oh = dcsag_pkg::bf16_floor(offset_h_bf16) - 32'(dcsag_pkg::OFFSET_BIAS);
		ow = dcsag_pkg::bf16_floor(offset_w_bf16) - 32'(dcsag_pkg::OFFSET_BIAS);

		col_stp = col_eff + cfg.q_step;
		wrap    = (col_stp >= cfg.q_end);
		col_nxt = wrap ? cfg.q_restart : col_stp;
		row_nxt = wrap ? (row_eff + cfg.p_step) : row_eff;

		last     = (lane_eff >= dcsag_pkg::LANE_W'(dcsag_pkg::SAMPLES_PER_FRAME - 1));
		lane_nxt = last ? '0 : (lane_eff + 1'b1);
		dst_nxt  = last ? '0 : (dst_eff + {4'b0, cfg.channels});

		push_item.h          = row_eff + tap_row + oh + {31'b0, corner_h};
		push_item.w          = col_eff + tap_col + ow + {31'b0, corner_w};
		push_item.image_base = image_base;
		push_item.dst_index  = dst_eff;
		push_item.p_next     = row_nxt;
		push_item.q_next     = col_nxt;
		push_item.last       = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			lane_q <= '0;
			dst_q  <= '0;
		end else if (push) begin
			row_q  <= row_nxt;
			col_q  <= col_nxt;
			lane_q <= lane_nxt;
			dst_q  <= dst_nxt;
		end
	end

	a_frame_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && last |=> (lane_q == '0) && (dst_q == '0))
		else $error("lane or destination not cleared after frame end");

endmodule

// ----- rtl/dcsag_queue.sv -----
module dcsag_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dcsag_pkg::item_t push_item,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output dcsag_pkg::item_t head
);

	dcsag_pkg::item_t               mem_q [dcsag_pkg::QUEUE_DEPTH];
	logic [dcsag_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [dcsag_pkg::QCNT_W-1:0]   count_q;
	logic                           do_pop;

	assign full       = (count_q == dcsag_pkg::QCNT_W'(dcsag_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == dcsag_pkg::QPTR_W'(dcsag_pkg::QUEUE_DEPTH - 1))
					? '0 : (wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == dcsag_pkg::QPTR_W'(dcsag_pkg::QUEUE_DEPTH - 1))
					? '0 : (rd_ptr_q + 1'b1);
			end
			case ({push && !full, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dcsag_pkg::QCNT_W'(dcsag_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

endmodule

// ----- rtl/dcsag_back.sv -----
module dcsag_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dcsag_pkg::cfg_t                 cfg,
	input  logic                            head_valid,
	input  dcsag_pkg::item_t                head,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dcsag_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                            m_tuser,
	output logic                            m_tlast
);

	// stage 1: bounds check and linear pixel index
	logic                         valid_s1;
	logic                         inside_s1;
	logic [dcsag_pkg::WORD_W-1:0] lin_s1;
	logic [dcsag_pkg::WORD_W-1:0] base_s1, p_s1, q_s1;
	logic [dcsag_pkg::DST_W-1:0]  dst_s1;
	logic                         last_s1;

	// stage 2: output register
	logic                         valid_s2;
	logic                         zero_fill_s2;
	logic [dcsag_pkg::WORD_W-1:0] src_s2, p_s2, q_s2;
	logic [dcsag_pkg::DST_W-1:0]  dst_s2;
	logic                         last_s2;

	logic                         adv_s2, load_s1, in_img;
	logic [dcsag_pkg::WORD_W-1:0] h_ext, w_ext, wid_ext, lin, ch_ext, src;

	assign adv_s2  = !valid_s2 || m_tready;
	assign load_s1 = !valid_s1 || adv_s2;
	assign pop     = head_valid && load_s1;

	always_comb begin
		in_img  = (head.h < {16'b0, cfg.img_height}) && (head.w < {16'b0, cfg.img_width});
		// inside the image both coordinates fit in 16 bits
		h_ext   = {16'b0, head.h[15:0]};
		w_ext   = {16'b0, head.w[15:0]};
		wid_ext = {16'b0, cfg.img_width};
		lin     = h_ext * wid_ext + w_ext;
		ch_ext  = {19'b0, cfg.channels};
		src     = base_s1 + lin_s1 * ch_ext;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			inside_s1 <= in_img;
			lin_s1    <= lin;
			base_s1   <= head.image_base;
			dst_s1    <= head.dst_index;
			p_s1      <= head.p_next;
			q_s1      <= head.q_next;
			last_s1   <= head.last;
		end
		if (adv_s2 && valid_s1) begin
			zero_fill_s2 <= !inside_s1;
			src_s2       <= inside_s1 ? src : '0;
			dst_s2       <= dst_s1;
			p_s2         <= p_s1;
			q_s2         <= q_s1;
			last_s2      <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= head_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = zero_fill_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {(dcsag_pkg::M_TDATA_W - dcsag_pkg::M_FIELDS_W)'(0),
		q_s2, p_s2, dst_s2, src_s2};

	a_zero_fill_src: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[31:0] == '0))
		else $error("zero fill result carries a source index");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1)
		else $error("stage 1 request dropped while output stalled");

endmodule

// ----- rtl/deform_conv_sample_address_gen_core.sv -----
// Deformable convolution gather address generator. Each input request carries
// two bfloat16 sampling offsets (biased by 63), kernel tap row/column terms,
// bilinear corner bits and the image base; the block floors the offsets, adds
// the running row/column terms and returns one result per request: zero_fill
// for positions outside the image, otherwise the source element index
// image_base + (row*img_width + col)*channels (mod 2^32), plus the destination
// slot, the stepped row/column terms and a frame-end flag every 32 samples.
// Sustained rate is one request per cycle while the output is not stalled;
// the limit is the front stage, which updates the running row/column terms
// once per request. A result passes through the two-entry queue (entered at
// the accepting edge), then bounds check and pixel multiply in stage 1, then
// the channel multiply into the output register. The queue lets the front
// keep taking requests while the output is stalled, until its two entries
// fill. Write configuration only while no request is in flight.
module deform_conv_sample_address_gen_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dcsag_pkg::IDX_W-1:0]     cfg_index,
	input  logic [dcsag_pkg::WORD_W-1:0]    cfg_data,
	// sample requests
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// p_init, q_init, offset_h_bf16, offset_w_bf16, tap_row, tap_col,
	// corner_h, corner_w, image_base, zero pad
	input  logic [dcsag_pkg::S_TDATA_W-1:0] s_tdata,
	// restart
	input  logic                            s_tuser,
	// address results
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// src_index, dst_index, p_next, q_next, zero pad
	output logic [dcsag_pkg::M_TDATA_W-1:0] m_tdata,
	// zero_fill
	output logic                            m_tuser,
	// last
	output logic                            m_tlast
);

	dcsag_pkg::cfg_t  cfg;
	dcsag_pkg::item_t push_item, head;
	logic             push, full, pop, head_valid;

	// register file
	dcsag_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// front: offset floor, position sums, running term update
	dcsag_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	dcsag_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: bounds check and index multiplies
	dcsag_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
